>>> hw/rtl/ring_buffer_deque_defines.svh
// Assertion macros shared by the deque checker.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define RBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a signal holds while its item waits to be taken.
`define RBD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  `RBD_ASSERT(lbl, (vld && !rdy) |=> $stable(sig), msg)

`endif

>>> hw/rtl/rbd_pkg.sv
// Package with the opcode, status and field-width constants of the deque.
package rbd_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [OPCODE_W-1:0] OP_PUSH_TAIL = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP_TAIL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_HEAD = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_HEAD  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

>>> hw/rtl/rbd_ram.sv
// Generic single-port RAM with a registered read port.
module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

>>> hw/rtl/ring_buffer_deque.sv
// Double-ended queue held in a circular RAM, with a result stage on the output.
// Throughput: one item per cycle unless output stalls; each item makes at most one access to
// the single RAM port. Results pass the first stage and then the output register.
// The result register lets a new item enter while an earlier result waits.
// Reset clears head, tail, count and all valid flags; the RAM contents stay undefined.
module ring_buffer_deque #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // push_value[31:0]
  input  logic [rbd_pkg::VALUE_W-1:0]        s_axis_tdata,
  // opcode[1:0]
  input  logic [rbd_pkg::OPCODE_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pop_value[31:0], entry_count[36:32], zero[39:37]
  output logic [rbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status[1:0]
  output logic [rbd_pkg::STATUS_W-1:0]       m_axis_tuser
);

  import rbd_pkg::*;

  localparam int unsigned IdxW   = $clog2(CAPACITY);
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned StoreW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic            accept, is_full, is_empty;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_addr;
  logic [StoreW-1:0] ram_rdata;
  logic [STATUS_W-1:0] status_d;

  logic                s1_valid_q;
  logic [STATUS_W-1:0] s1_status_q;
  logic [CntW-1:0]     s1_count_q;
  logic                s1_pop_q;
  logic                s1_adv;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [STATUS_W-1:0]   out_status_q;
  logic [CntW+COUNT_W-1:0]  count_ext;
  logic [VALUE_W+StoreW-1:0] value_ext;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_full  = (count_q == FullCnt);
  assign is_empty = (count_q == '0);
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LastIdx : tail_q - 1'b1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = tail_q;
    status_d = ST_OK;
    case (s_axis_tuser)
      OP_PUSH_TAIL: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          ram_we   = accept;
          ram_addr = tail_q;
          tail_d   = tail_inc;
          count_d  = count_q + 1'b1;
        end
      end
      OP_POP_TAIL: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          ram_re   = accept;
          ram_addr = tail_dec;
          tail_d   = tail_dec;
          count_d  = count_q - 1'b1;
        end
      end
      OP_PUSH_HEAD: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          ram_we   = accept;
          ram_addr = head_dec;
          head_d   = head_dec;
          count_d  = count_q + 1'b1;
        end
      end
      default: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          ram_re   = accept;
          ram_addr = head_q;
          head_d   = head_inc;
          count_d  = count_q - 1'b1;
        end
      end
    endcase
  end

  rbd_ram #(
    .WIDTH(StoreW),
    .DEPTH(CAPACITY)
  ) u_rbd_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(s_axis_tdata[StoreW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, s1_count_q};
  assign value_ext = {{VALUE_W{1'b0}}, ram_rdata};

  always_comb begin
    out_data_d = '0;
    out_data_d[COUNT_W+VALUE_W-1:VALUE_W] = count_ext[COUNT_W-1:0];
    if (s1_pop_q) begin
      out_data_d[VALUE_W-1:0] = value_ext[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_d;
      s1_count_q  <= count_d;
      s1_pop_q    <= ram_re;
    end
    if (s1_adv) begin
      out_data_q   <= out_data_d;
      out_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

>>> hw/rtl/rbd_checker.sv
// Port-level checker for the deque, bound to the top level.
`include "ring_buffer_deque_defines.svh"

module rbd_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rbd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [rbd_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import rbd_pkg::*;

  localparam logic [COUNT_W-1:0] CapLow = COUNT_W'(CAPACITY);

  logic               out_hs, in_hs;
  logic [COUNT_W-1:0] out_count, last_count_q, delta;
  logic [VALUE_W-1:0] out_value;
  logic               step_ok, empty_res, full_res;
  logic [1:0]         flight_q;

  assign in_hs     = s_axis_tvalid && s_axis_tready;
  assign out_hs    = m_axis_tvalid && m_axis_tready;
  assign out_count = m_axis_tdata[COUNT_W+VALUE_W-1:VALUE_W];
  assign out_value = m_axis_tdata[VALUE_W-1:0];
  assign empty_res = m_axis_tvalid && (m_axis_tuser == ST_EMPTY);
  assign full_res  = m_axis_tvalid && (m_axis_tuser == ST_FULL);
  assign delta     = out_count - last_count_q;
  assign step_ok   = (m_axis_tuser == ST_OK) ? (delta == 5'd1 || delta == 5'd31)
                                             : (delta == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      flight_q     <= '0;
    end else begin
      if (out_hs) begin
        last_count_q <= out_count;
      end
      if (in_hs && !out_hs) begin
        flight_q <= flight_q + 2'd1;
      end else if (out_hs && !in_hs) begin
        flight_q <= flight_q - 2'd1;
      end
    end
  end

  `RBD_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "Result changed.")
  `RBD_ASSERT(a_empty_zero, empty_res |-> (out_count == '0 && out_value == '0), "Bad empty.")
  `RBD_ASSERT(a_full_count, full_res |-> (out_count == CapLow && out_value == '0), "Bad full.")
  `RBD_ASSERT(a_count_step, out_hs |-> step_ok, "Entry count moved by other than one step.")
  `RBD_ASSERT(a_result_owed, m_axis_tvalid |-> (flight_q != '0), "Result without an item.")

endmodule

bind ring_buffer_deque rbd_checker #(.CAPACITY(CAPACITY)) u_rbd_checker (.*);
